// ----- rtl/core/pcf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcf_pkg
// shared types and constants of the polyline crossing finder
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int COORD_W    = 16;  // point coordinate
  localparam int DIFF_W     = 17;  // coordinate difference
  localparam int PROD_W     = 34;  // product of two differences
  localparam int CROSS_W    = 35;  // cross product
  localparam int MAG_W      = 16;  // magnitude of a difference
  localparam int NUM_W      = 50;  // |delta| * t numerator
  localparam int DVS_W      = 34;  // normalized divisor and remainder
  localparam int QUO_W      = 24;  // quotient bits
  localparam int OUT_W      = 24;  // Q16.8 result
  localparam int IDX_W      = 5;   // segment index field
  localparam int FIX_W      = 27;  // signed working width of the result
  localparam int FRAC_W     = 8;
  localparam int CROSS_STEPS = 6;
  localparam int DIV_STEPS  = 24;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_LD_A,
    S_LD_B,
    S_DIFF,
    S_CROSS,
    S_NORM,
    S_CHECK,
    S_PRODX,
    S_PRODY,
    S_DINIT,
    S_DIV,
    S_FIX,
    S_EMIT,
    S_ADV,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RD_SEG,
    RD_SEG1,
    RD_SEG2
  } rd_sel_t;

  typedef struct packed {
    logic       accept;
    rd_sel_t    rd_sel;
    logic       load_a;
    logic       load_b;
    logic       shift_ab;
    logic       seg_inc;
    logic       diff_en;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       acc_en;
    logic [2:0] acc_step;
    logic       norm_en;
    logic       prod_en;
    logic       prod_y;
    logic       init_x;
    logic       init_y;
    logic       div_step;
    logic       fix_en;
    logic       emit;
    logic       push;
    logic       push_last;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic scan_ok;
    logic hit;
    logic seg_more;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/pcf_channels.sv -----
// ----------------------------------------------------------------------------
// pcf channels
// point input channel and crossing output channel
// ----------------------------------------------------------------------------
interface pcf_pt_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic               first;
  logic signed [15:0] px;
  logic signed [15:0] py;

  modport source (output valid, output op, output first, output px, output py, input ready);
  modport sink (input valid, input op, input first, input px, input py, output ready);
endinterface

interface pcf_hit_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] ix;
  logic signed [23:0] iy;
  logic [4:0]         seg_index;
  logic               last;

  modport source (output valid, output ix, output iy, output seg_index, output last,
                  input ready);
  modport sink (input valid, input ix, input iy, input seg_index, input last,
                output ready);
endinterface

// ----- rtl/core/pcf_datapath.sv -----
// ----------------------------------------------------------------------------
// pcf_datapath
// point store, cross products, dual divider and result registers
// ----------------------------------------------------------------------------
module pcf_datapath
  import pcf_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     op,
  input  logic                     first,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_ix,
  output logic signed [OUT_W-1:0]  out_iy,
  output logic [IDX_W-1:0]         out_idx,
  output logic                     out_last
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_data;
  logic [AW-1:0]        rd_addr;

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_eff;
  logic [2*COORD_W-1:0] prev_point;
  logic                 prev_valid;
  logic [AW-1:0]        seg;

  logic [2*COORD_W-1:0] a_pt, b_pt, c_pt, d_pt;
  logic signed [DIFF_W-1:0] abx, aby, cdx, cdy, cax, cay;
  logic signed [DIFF_W-1:0] ma, mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [CROSS_W-1:0] dv, tn, un;
  logic [NUM_W-1:0]     np;
  logic [MAG_W-1:0]     mag_sel;
  logic [DVS_W-1:0]     rx, ry;
  logic [QUO_W-1:0]     qx, qy;
  logic [DVS_W:0]       tx, ty;
  logic signed [OUT_W-1:0] new_x, new_y;
  logic signed [OUT_W-1:0] hold_x, hold_y;
  logic [IDX_W-1:0]     hold_idx;
  logic                 hold_valid;
  logic                 out_free;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // truncate toward zero: base*256 + sign*(q + r) / dv
  function automatic logic signed [OUT_W-1:0] fix_coord(
    input logic signed [COORD_W-1:0] base,
    input logic                      neg,
    input logic [QUO_W-1:0]          q,
    input logic                      rnz
  );
    logic signed [FIX_W-1:0] b;
    logic signed [FIX_W-1:0] qe;
    logic signed [FIX_W-1:0] f;
    b  = {{(FIX_W-COORD_W-FRAC_W){base[COORD_W-1]}}, base, {FRAC_W{1'b0}}};
    qe = {{(FIX_W-QUO_W){1'b0}}, q};
    f  = neg ? (b - qe - FIX_W'(rnz)) : (b + qe);
    if (rnz && f[FIX_W-1]) begin
      f = f + FIX_W'(1);
    end
    return f[OUT_W-1:0];
  endfunction

  assign count_eff = first ? '0 : count;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SEG:  rd_addr = seg;
      RD_SEG1: rd_addr = AW'({1'b0, seg} + (AW+1)'(1));
      RD_SEG2: rd_addr = AW'({1'b0, seg} + (AW+1)'(2));
      default: rd_addr = seg;
    endcase
  end

  // point store
  always_ff @(posedge clk) begin
    if (cmd.accept && !op && (count_eff < CW'(MAX_POINTS))) begin
      mem[count_eff[AW-1:0]] <= {py, px};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_point <= '0;
      prev_valid <= 1'b0;
    end else if (cmd.accept) begin
      if (!op) begin
        if (count_eff < CW'(MAX_POINTS)) begin
          count <= count_eff + CW'(1);
        end else begin
          count <= count_eff;
        end
      end else begin
        prev_point <= {py, px};
        prev_valid <= 1'b1;
      end
    end
  end

  // segment registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_pt <= prev_point;
      d_pt <= {py, px};
      seg  <= '0;
    end
    if (cmd.seg_inc) seg <= seg + AW'(1);
    if (cmd.load_a) a_pt <= rd_data;
    if (cmd.shift_ab) a_pt <= b_pt;
    if (cmd.load_b) b_pt <= rd_data;
    if (cmd.diff_en) begin
      abx <= DIFF_W'($signed(b_pt[15:0])) - DIFF_W'($signed(a_pt[15:0]));
      aby <= DIFF_W'($signed(b_pt[31:16])) - DIFF_W'($signed(a_pt[31:16]));
      cdx <= DIFF_W'($signed(d_pt[15:0])) - DIFF_W'($signed(c_pt[15:0]));
      cdy <= DIFF_W'($signed(d_pt[31:16])) - DIFF_W'($signed(c_pt[31:16]));
      cax <= DIFF_W'($signed(c_pt[15:0])) - DIFF_W'($signed(a_pt[15:0]));
      cay <= DIFF_W'($signed(c_pt[31:16])) - DIFF_W'($signed(a_pt[31:16]));
    end
  end

  // shared cross product multiplier
  always_comb begin
    unique case (cmd.mul_step)
      3'd0:    begin ma = abx; mb = cdy; end
      3'd1:    begin ma = aby; mb = cdx; end
      3'd2:    begin ma = cax; mb = cdy; end
      3'd3:    begin ma = cay; mb = cdx; end
      3'd4:    begin ma = cax; mb = aby; end
      3'd5:    begin ma = cay; mb = abx; end
      default: begin ma = '0;  mb = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.acc_en) begin
      unique case (cmd.acc_step)
        3'd0:    dv <= CROSS_W'(prod);
        3'd1:    dv <= dv - CROSS_W'(prod);
        3'd2:    tn <= CROSS_W'(prod);
        3'd3:    tn <= tn - CROSS_W'(prod);
        3'd4:    un <= CROSS_W'(prod);
        3'd5:    un <= un - CROSS_W'(prod);
        default: dv <= dv;
      endcase
    end
    if (cmd.norm_en && dv[CROSS_W-1]) begin
      dv <= -dv;
      tn <= -tn;
      un <= -un;
    end
  end

  assign mag_sel = cmd.prod_y ? mag(aby) : mag(abx);

  // dual restoring divider, quotient bounded by |delta| * 256
  assign tx = {rx, qx[QUO_W-1]};
  assign ty = {ry, qy[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.prod_en) np <= mag_sel * tn[DVS_W-1:0];
    if (cmd.init_x) begin
      rx <= np[NUM_W-1:MAG_W];
      qx <= {np[MAG_W-1:0], {FRAC_W{1'b0}}};
    end
    if (cmd.init_y) begin
      ry <= np[NUM_W-1:MAG_W];
      qy <= {np[MAG_W-1:0], {FRAC_W{1'b0}}};
    end
    if (cmd.div_step) begin
      if (tx >= {1'b0, dv[DVS_W-1:0]}) begin
        rx <= DVS_W'(tx - {1'b0, dv[DVS_W-1:0]});
        qx <= {qx[QUO_W-2:0], 1'b1};
      end else begin
        rx <= tx[DVS_W-1:0];
        qx <= {qx[QUO_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv[DVS_W-1:0]}) begin
        ry <= DVS_W'(ty - {1'b0, dv[DVS_W-1:0]});
        qy <= {qy[QUO_W-2:0], 1'b1};
      end else begin
        ry <= ty[DVS_W-1:0];
        qy <= {qy[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.fix_en) begin
      new_x <= fix_coord($signed(a_pt[15:0]), abx[DIFF_W-1], qx, rx != '0);
      new_y <= fix_coord($signed(a_pt[31:16]), aby[DIFF_W-1], qy, ry != '0);
    end
  end

  // one crossing held back until the next one shows whether it is the last
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hold_x   <= new_x;
      hold_y   <= new_y;
      hold_idx <= IDX_W'(seg);
    end
    if (cmd.push) begin
      out_ix   <= hold_x;
      out_iy   <= hold_y;
      out_idx  <= hold_idx;
      out_last <= cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) hold_valid <= 1'b1;
      else if (cmd.flush) hold_valid <= 1'b0;
      if (cmd.push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.scan_ok    = op && !first && prev_valid && (count >= CW'(2));
    sts.hit        = (dv != '0) && !tn[CROSS_W-1] && !un[CROSS_W-1] && (tn <= dv) && (un <= dv);
    sts.seg_more   = ((CW+1)'(seg) + (CW+1)'(2)) < (CW+1)'(count);
    sts.hold_valid = hold_valid;
    sts.out_free   = out_free;
  end

`ifndef SYNTH
  a_push_free: assert property (@(posedge clk) disable iff (rst) cmd.push |-> out_free)
    else $error("result pushed over a word not yet taken");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && cmd.push_last) |=> !hold_valid)
    else $error("held crossing survives the last word");
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_POINTS))
    else $error("stored point count above capacity");
`endif

endmodule

// ----- rtl/core/pcf_controller.sv -----
// ----------------------------------------------------------------------------
// pcf_controller
// sequencer for segment scan, cross products, division and emission
// ----------------------------------------------------------------------------
module pcf_controller
  import pcf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [2:0] mcnt;
  logic [4:0] dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mcnt  <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      mcnt  <= (state == S_CROSS) ? mcnt + 3'd1 : '0;
      dcnt  <= (state == S_DIV) ? dcnt + 5'd1 : '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && sts.scan_ok) state_next = S_RD_A;
      S_RD_A:  state_next = S_LD_A;
      S_LD_A:  state_next = S_LD_B;
      S_LD_B:  state_next = S_DIFF;
      S_DIFF:  state_next = S_CROSS;
      S_CROSS: if (mcnt == 3'(CROSS_STEPS)) state_next = S_NORM;
      S_NORM:  state_next = S_CHECK;
      S_CHECK: state_next = sts.hit ? S_PRODX : S_ADV;
      S_PRODX: state_next = S_PRODY;
      S_PRODY: state_next = S_DINIT;
      S_DINIT: state_next = S_DIV;
      S_DIV:   if (dcnt == 5'(DIV_STEPS - 1)) state_next = S_FIX;
      S_FIX:   state_next = S_EMIT;
      S_EMIT:  if (!sts.hold_valid || sts.out_free) state_next = S_ADV;
      S_ADV:   state_next = sts.seg_more ? S_LD_B : S_FLUSH;
      S_FLUSH: if (!sts.hold_valid || sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_SEG;
    cmd.mul_step = mcnt;
    cmd.acc_step = mcnt - 3'd1;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_RD_A:  cmd.rd_sel = RD_SEG;
      S_LD_A: begin
        cmd.load_a = 1'b1;
        cmd.rd_sel = RD_SEG1;
      end
      S_LD_B:  cmd.load_b = 1'b1;
      S_DIFF:  cmd.diff_en = 1'b1;
      S_CROSS: begin
        cmd.mul_en = (mcnt < 3'(CROSS_STEPS));
        cmd.acc_en = (mcnt != 3'd0);
      end
      S_NORM:  cmd.norm_en = 1'b1;
      S_CHECK: cmd.rd_sel = RD_SEG;
      S_PRODX: cmd.prod_en = 1'b1;
      S_PRODY: begin
        cmd.init_x  = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.prod_y  = 1'b1;
      end
      S_DINIT: cmd.init_y = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIX:   cmd.fix_en = 1'b1;
      S_EMIT: begin
        if (!sts.hold_valid || sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.push = sts.hold_valid;
        end
      end
      S_ADV: begin
        if (sts.seg_more) begin
          cmd.rd_sel   = RD_SEG2;
          cmd.shift_ab = 1'b1;
          cmd.seg_inc  = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.hold_valid && sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          cmd.flush     = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sts.hold_valid)
    else $error("crossing left behind after a scan");
  a_store_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !sts.scan_ok) |=> state == S_IDLE)
    else $error("word without a scan left idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dcnt < 5'(DIV_STEPS))
    else $error("divider ran past its quotient width");
`endif

endmodule

// ----- rtl/core/polyline_crossing_finder.sv -----
// ----------------------------------------------------------------------------
// polyline_crossing_finder
// crossings of a streamed polyline with a stored one, Q16.8 results
// ----------------------------------------------------------------------------
//  channel  dir  payload                      meaning
//  pts      in   op, first, px, py            one point word
//  hits     out  ix, iy, seg_index, last      one crossing word
//
//  a store word, like a second-path word that starts no scan, leaves the block idle;
//  a scan over n >= 2 stored points runs the shared cross product multiplier
//  (6 products per segment) for every segment and the 24-step restoring divider
//  for every crossing
//  reset clears point count and previous point; the store itself is not cleared
//  a new word is taken only while no scan runs; a full result register stalls
//  the scan at the next crossing or at its end, never the held word
module polyline_crossing_finder
  import pcf_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input logic           clk,
  input logic           rst,
  pcf_pt_if.sink        pts,
  pcf_hit_if.source     hits
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pcf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pts.valid),
    .in_ready (pts.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, arithmetic and result register
  pcf_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (pts.op),
    .first     (pts.first),
    .px        (pts.px),
    .py        (pts.py),
    .out_valid (hits.valid),
    .out_ready (hits.ready),
    .out_ix    (hits.ix),
    .out_iy    (hits.iy),
    .out_idx   (hits.seg_index),
    .out_last  (hits.last)
  );

endmodule
